// ===== hw/rtl/jsu_pkg.sv =====
package jsu_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CLOSED = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    // one raw byte of the string body
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in_item;

    // one decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       last;
    } t_out_item;

    // all results caused by one input item, first byte in slot 0
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
        t_kind           kind;
    } t_grp;

endpackage

// ===== hw/rtl/jsu_decode.sv =====
module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  jsu_pkg::t_in_item i_item,
    output logic             o_grp_valid,
    output jsu_pkg::t_grp    o_grp
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_MAX = 8'h1F;

    typedef enum logic [2:0] {
        M_NORMAL  = 3'd0,
        M_ESCAPE  = 3'd1,
        M_HEX1    = 3'd2,
        M_BSLASH2 = 3'd3,
        M_U2      = 3'd4,
        M_HEX2    = 3'd5
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [11:0] r_accum, n_accum;
    logic [1:0]  r_count, n_count;
    logic [9:0]  r_high, n_high;

    logic [7:0]  b;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] v;
    logic [20:0] cp;
    logic        v_high, v_low;
    jsu_pkg::t_grp enc_grp;

    assign b = i_item.in_byte;

    // hex digit value, either case
    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hex_d = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hex_d = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hex_d = 4'(b - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign v      = {r_accum, hex_d};
    assign v_high = (v >= 16'hD800) && (v <= 16'hDBFF);
    assign v_low  = (v >= 16'hDC00) && (v <= 16'hDFFF);

    // code point from the completed hex field
    always_comb begin
        if (r_mode == M_HEX1) begin
            cp = {5'd0, v};
        end else if (v_low) begin
            cp = {1'b0, r_high, v[9:0]} + 21'h10000;
        end else begin
            cp = 21'h00FFFD;
        end
    end

    // utf-8 encoding of the code point
    always_comb begin
        enc_grp = '0;
        enc_grp.kind = jsu_pkg::KIND_DATA;
        if (cp < 21'h80) begin
            enc_grp.last_idx = 2'd0;
            enc_grp.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            enc_grp.last_idx = 2'd1;
            enc_grp.bytes[0] = {3'b110, cp[10:6]};
            enc_grp.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            enc_grp.last_idx = 2'd2;
            enc_grp.bytes[0] = {4'b1110, cp[15:12]};
            enc_grp.bytes[1] = {2'b10, cp[11:6]};
            enc_grp.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            enc_grp.last_idx = 2'd3;
            enc_grp.bytes[0] = {5'b11110, cp[20:18]};
            enc_grp.bytes[1] = {2'b10, cp[17:12]};
            enc_grp.bytes[2] = {2'b10, cp[11:6]};
            enc_grp.bytes[3] = {2'b10, cp[5:0]};
        end
    end

    // next state and result group for the current item
    always_comb begin
        logic fail;
        fail        = 1'b0;
        n_mode      = r_mode;
        n_accum     = r_accum;
        n_count     = r_count;
        n_high      = r_high;
        o_grp_valid = 1'b0;
        o_grp       = '0;
        o_grp.kind  = jsu_pkg::KIND_DATA;

        if (i_item.stream_end) begin
            fail = 1'b1;
        end else begin
            unique case (r_mode)
                M_NORMAL: begin
                    if (b <= CTRL_MAX) begin
                        fail = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        o_grp_valid = 1'b1;
                        o_grp.kind  = jsu_pkg::KIND_CLOSED;
                        n_accum     = '0;
                        n_count     = '0;
                        n_high      = '0;
                    end else if (b == CH_BSL) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        o_grp_valid    = 1'b1;
                        o_grp.bytes[0] = b;
                    end
                end
                M_ESCAPE: begin
                    n_mode = M_NORMAL;
                    o_grp_valid = 1'b1;
                    unique case (b)
                        CH_BSL, CH_QUOTE, CH_SLASH: o_grp.bytes[0] = b;
                        CH_B: o_grp.bytes[0] = 8'h08;
                        CH_T: o_grp.bytes[0] = 8'h09;
                        CH_N: o_grp.bytes[0] = 8'h0A;
                        CH_F: o_grp.bytes[0] = 8'h0C;
                        CH_R: o_grp.bytes[0] = 8'h0D;
                        CH_U: begin
                            o_grp_valid = 1'b0;
                            n_mode      = M_HEX1;
                            n_accum     = '0;
                            n_count     = '0;
                        end
                        default: begin
                            o_grp_valid = 1'b0;
                            fail        = 1'b1;
                        end
                    endcase
                end
                M_HEX1, M_HEX2: begin
                    if (!hex_ok) begin
                        fail = 1'b1;
                    end else if (r_count != 2'd3) begin
                        n_accum = v[11:0];
                        n_count = r_count + 2'd1;
                    end else begin
                        n_accum = '0;
                        n_count = '0;
                        if (r_mode == M_HEX1 && v_high) begin
                            n_high = v[9:0];
                            n_mode = M_BSLASH2;
                        end else begin
                            n_mode      = M_NORMAL;
                            n_high      = '0;
                            o_grp_valid = (cp != 21'd0);
                            o_grp       = enc_grp;
                        end
                    end
                end
                M_BSLASH2: begin
                    if (b != CH_BSL) begin
                        fail = 1'b1;
                    end else begin
                        n_mode = M_U2;
                    end
                end
                M_U2: begin
                    if (b != CH_U) begin
                        fail = 1'b1;
                    end else begin
                        n_mode  = M_HEX2;
                        n_accum = '0;
                        n_count = '0;
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
        end

        // error clears everything
        if (fail) begin
            n_mode      = M_NORMAL;
            n_accum     = '0;
            n_count     = '0;
            n_high      = '0;
            o_grp_valid = 1'b1;
            o_grp       = '0;
            o_grp.kind  = jsu_pkg::KIND_ERROR;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_accum <= '0;
            r_count <= '0;
            r_high  <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_count <= n_count;
            r_high  <= n_high;
        end
    end

endmodule

// ===== hw/rtl/jsu_emit.sv =====
module jsu_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  jsu_pkg::t_grp      i_grp,
    output logic               o_full,
    output logic               o_out_valid,
    output jsu_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    logic          r_valid;
    logic [1:0]    r_idx;
    jsu_pkg::t_grp r_grp;
    logic          out_acc;
    logic          at_last;

    assign out_acc = r_valid && !i_out_stall;
    assign at_last = (r_idx == r_grp.last_idx);

    // group register can take a new group once its last item leaves
    assign o_full = r_valid && !(out_acc && at_last);

    // output item from the current slot
    assign o_out_valid         = r_valid;
    assign o_out_data.out_byte = r_grp.bytes[r_idx];
    assign o_out_data.kind     = r_grp.kind;
    assign o_out_data.last     = at_last;

    // occupancy and slot pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (out_acc) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // group payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

endmodule

// ===== hw/rtl/json_string_unescape.sv =====
// JSON string body decoder: takes one raw byte per item after the opening quote
// and gives decoded UTF-8 bytes, a closed marker at the closing quote, or an
// error marker (control byte, unknown escape, bad hex digit, missing second
// \u after a high surrogate, or end of input), after which it starts a new
// string. An item is taken every cycle as long as each item gives at most one
// result and the output is not stalled; an item that completes a \u escape
// gives up to four bytes (none for \u0000) and the input is held until all
// results of the item, held in a single group register, are read out one
// byte per cycle unless stalled, starting in the cycle after the item is taken.
module json_string_unescape (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  jsu_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output jsu_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    logic          in_acc;
    logic          grp_valid;
    jsu_pkg::t_grp grp;
    logic          full;

    assign o_in_stall = full;
    assign in_acc     = i_in_valid && !full;

    // escape and code point decode
    jsu_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_acc),
        .i_item     (i_in_data),
        .o_grp_valid(grp_valid),
        .o_grp      (grp)
    );

    // result group register and byte serializer
    jsu_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_acc && grp_valid),
        .i_grp      (grp),
        .o_full     (full),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

endmodule
